// File: hdl/ccksb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Color-keyed sprite blitter package
// Shared types, register indexes and widths for the sprite blitter.
// ----------------------------------------------------------------------------
package ccksb_pkg;

    localparam int DEF_SCREEN_WIDTH  = 80;
    localparam int DEF_SCREEN_HEIGHT = 64;

    localparam int ADDR_W  = 13;
    localparam int PIX_W   = 16;
    localparam int CFG_W   = 17;
    localparam int IDX_W   = 3;
    localparam int POS_W   = 10;

    localparam logic [IDX_W-1:0] REG_DEST_X        = 3'd0;
    localparam logic [IDX_W-1:0] REG_DEST_Y        = 3'd1;
    localparam logic [IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd2;
    localparam logic [IDX_W-1:0] REG_SPRITE_HEIGHT = 3'd3;
    localparam logic [IDX_W-1:0] REG_KEY_COLOR     = 3'd4;
    localparam logic [IDX_W-1:0] REG_PIXEL_MODE    = 3'd5;

    localparam logic MODE_8BIT  = 1'b0;
    localparam logic MODE_16BIT = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
        logic             first_pixel;
    } in_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] write_address;
        logic [PIX_W-1:0]  write_value;
    } out_item_t;

    typedef struct packed {
        logic signed [8:0]  dest_x;
        logic signed [8:0]  dest_y;
        logic [7:0]         sprite_width;
        logic [7:0]         sprite_height;
        logic signed [16:0] key_color;
        logic               pixel_mode;
    } cfg_t;

    typedef struct packed {
        logic signed [POS_W-1:0] sx;
        logic signed [POS_W-1:0] sy;
        logic [PIX_W-1:0]        pix;
    } place_t;

endpackage : ccksb_pkg
`default_nettype wire

// File: hdl/ccksb_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the destination, sprite size, color key and pixel mode.
// ----------------------------------------------------------------------------
module ccksb_cfg (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [ccksb_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [ccksb_pkg::CFG_W-1:0] cfg_data,
    output ccksb_pkg::cfg_t               cfg
);
    import ccksb_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dest_x        <= '0;
            cfg_reg.dest_y        <= '0;
            cfg_reg.sprite_width  <= 8'd1;
            cfg_reg.sprite_height <= 8'd1;
            cfg_reg.key_color     <= '1;
            cfg_reg.pixel_mode    <= MODE_8BIT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEST_X:        cfg_reg.dest_x        <= cfg_data[8:0];
                REG_DEST_Y:        cfg_reg.dest_y        <= cfg_data[8:0];
                REG_SPRITE_WIDTH:  cfg_reg.sprite_width  <= cfg_data[7:0];
                REG_SPRITE_HEIGHT: cfg_reg.sprite_height <= cfg_data[7:0];
                REG_KEY_COLOR:     cfg_reg.key_color     <= cfg_data;
                REG_PIXEL_MODE:    cfg_reg.pixel_mode    <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule : ccksb_cfg
`default_nettype wire

// File: hdl/ccksb_track.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite position tracker
// Steps the column and row counters and registers each item with its screen
// position.
// ----------------------------------------------------------------------------
module ccksb_track (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ccksb_pkg::cfg_t     cfg,
    input  wire logic                in_fire,
    input  wire ccksb_pkg::in_item_t in_data,
    input  wire logic                stage_move,
    output logic                     stage_valid,
    output ccksb_pkg::place_t        stage_data
);
    import ccksb_pkg::*;

    logic [7:0] column_count_reg;
    logic [7:0] column_count_next;
    logic [7:0] row_count_reg;
    logic [7:0] row_count_next;
    logic       stage_valid_reg;
    logic       stage_valid_next;
    place_t     stage_data_reg;
    place_t     stage_data_next;

    logic [7:0] col_cur;
    logic [7:0] row_cur;
    logic [7:0] col_last;
    logic [7:0] row_last;

    always_comb
    begin
        col_cur  = in_data.first_pixel ? 8'd0 : column_count_reg;
        row_cur  = in_data.first_pixel ? 8'd0 : row_count_reg;
        col_last = (cfg.sprite_width  == 8'd0) ? 8'd0 : cfg.sprite_width  - 8'd1;
        row_last = (cfg.sprite_height == 8'd0) ? 8'd0 : cfg.sprite_height - 8'd1;

        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (in_fire)
        begin
            if (col_cur >= col_last)
            begin
                column_count_next = 8'd0;
                row_count_next    = (row_cur >= row_last) ? 8'd0 : row_cur + 8'd1;
            end
            else
            begin
                column_count_next = col_cur + 8'd1;
                row_count_next    = row_cur;
            end
        end

        stage_data_next.sx  = POS_W'(cfg.dest_x) + $signed({2'b00, col_cur});
        stage_data_next.sy  = POS_W'(cfg.dest_y) + $signed({2'b00, row_cur});
        stage_data_next.pix = (cfg.pixel_mode == MODE_8BIT)
                            ? {8'h00, in_data.pixel_value[7:0]}
                            : in_data.pixel_value;

        if (in_fire)
            stage_valid_next = 1'b1;
        else if (stage_move)
            stage_valid_next = 1'b0;
        else
            stage_valid_next = stage_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            stage_valid_reg  <= 1'b0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            stage_valid_reg  <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            stage_data_reg <= stage_data_next;
    end

    assign stage_valid = stage_valid_reg;
    assign stage_data  = stage_data_reg;

endmodule : ccksb_track
`default_nettype wire

// File: hdl/ccksb_place.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Clip, key and address stage
// Drops off-screen and keyed pixels and registers the screen write.
// ----------------------------------------------------------------------------
module ccksb_place #(
    parameter int SCREEN_WIDTH  = ccksb_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = ccksb_pkg::DEF_SCREEN_HEIGHT
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ccksb_pkg::cfg_t     cfg,
    input  wire logic                stage_valid,
    input  wire ccksb_pkg::place_t   stage_data,
    output logic                     stage_move,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output ccksb_pkg::out_item_t     out_data
);
    import ccksb_pkg::*;

    localparam logic [10:0] SW_L = 11'(SCREEN_WIDTH);
    localparam logic [10:0] SH_L = 11'(SCREEN_HEIGHT);

    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_data_reg;
    out_item_t out_data_next;
    logic      on_screen;
    logic      keyed;
    logic      keep;

    always_comb
    begin
        on_screen = !stage_data.sx[POS_W-1] && !stage_data.sy[POS_W-1]
                 && ({2'b00, stage_data.sx[8:0]} < SW_L)
                 && ({2'b00, stage_data.sy[8:0]} < SH_L);
        keyed = !cfg.key_color[16] && (cfg.key_color[15:0] == stage_data.pix);
        keep  = stage_valid && on_screen && !keyed;

        stage_move = !out_valid_reg || out_ready;

        out_data_next.write_address = ADDR_W'(stage_data.sy[8:0]) * ADDR_W'(SW_L)
                                    + ADDR_W'(stage_data.sx[8:0]);
        out_data_next.write_value = stage_data.pix;

        if (stage_move)
            out_valid_next = keep;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (stage_move && keep)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule : ccksb_place
`default_nettype wire

// File: hdl/clipped_color_key_sprite_blit.sv
`default_nettype none
// Stages: two register stages; an accepted item is held in the input register
// and then in the result register, which offers its screen write.
// Throughput: one item per cycle; the input register and result register
// advance together whenever the result register is empty or taken.
// Reset: asynchronous and active low; clears the counters, the valid flags
// and the configuration registers to their defaults.
// ----------------------------------------------------------------------------
// Color-keyed sprite blitter with clipping
// Places sprite pixels on the screen, drops clipped and keyed ones and emits
// one screen write for each remaining item.
// ----------------------------------------------------------------------------
module clipped_color_key_sprite_blit #(
    parameter int SCREEN_WIDTH  = ccksb_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = ccksb_pkg::DEF_SCREEN_HEIGHT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire ccksb_pkg::in_item_t         in_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output ccksb_pkg::out_item_t             out_data,
    input  wire logic                        cfg_we,
    input  wire logic [ccksb_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [ccksb_pkg::CFG_W-1:0] cfg_data
);
    import ccksb_pkg::*;

    cfg_t   cfg;
    logic   in_fire;
    logic   stage_valid;
    logic   stage_move;
    place_t stage_data;

    assign in_ready = !stage_valid || stage_move;
    assign in_fire  = in_valid && in_ready;

    ccksb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ccksb_track u_track (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_fire     (in_fire),
        .in_data     (in_data),
        .stage_move  (stage_move),
        .stage_valid (stage_valid),
        .stage_data  (stage_data)
    );

    ccksb_place #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_place (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .stage_valid (stage_valid),
        .stage_data  (stage_data),
        .stage_move  (stage_move),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule : clipped_color_key_sprite_blit
`default_nettype wire

// File: hdl/ccksb_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Port checker
// Watches the blitter ports for stalls, keyed writes and address range.
// ----------------------------------------------------------------------------
module ccksb_check #(
    parameter int SCREEN_WIDTH  = ccksb_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = ccksb_pkg::DEF_SCREEN_HEIGHT
) (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire ccksb_pkg::out_item_t        out_data,
    input wire logic                        cfg_we,
    input wire logic [ccksb_pkg::IDX_W-1:0] cfg_index,
    input wire logic [ccksb_pkg::CFG_W-1:0] cfg_data
);
    import ccksb_pkg::*;

    localparam int  AREA    = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam bit  AREA_OK = (AREA <= (1 << ADDR_W));
    localparam logic [ADDR_W:0] AREA_L = (ADDR_W+1)'(AREA);

    logic [CFG_W-1:0] key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_reg <= '1;
        else if (cfg_we && (cfg_index == REG_KEY_COLOR))
            key_reg <= cfg_data;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("Result item changed while stalled.");

    a_no_keyed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (key_reg[CFG_W-1] || (key_reg[PIX_W-1:0] != out_data.write_value)))
        else $error("Keyed pixel was written.");

    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && AREA_OK) |-> ({1'b0, out_data.write_address} < AREA_L))
        else $error("Write address beyond the screen.");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ready || !out_valid) |-> in_ready)
        else $error("Input stalled although the result side can move.");

endmodule : ccksb_check

bind clipped_color_key_sprite_blit ccksb_check #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_ccksb_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);
`default_nettype wire

// File: tb/clipped_color_key_sprite_blit_test.sv
// ----------------------------------------------------------------------------
// Sprite blitter testbench
// Streams sprite pixels into the blitter under several placements, sizes,
// color keys and pixel modes, predicts each screen write in step with the
// input handshake and checks every write against the oldest prediction.
// ----------------------------------------------------------------------------
module clipped_color_key_sprite_blit_test;

    import ccksb_pkg::*;

    localparam int SCR_W = DEF_SCREEN_WIDTH;
    localparam int SCR_H = DEF_SCREEN_HEIGHT;
    localparam int HOLD_CYCLES = 80;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    in_item_t            in_data;
    logic                out_valid;
    logic                out_ready;
    out_item_t           out_data;
    logic                cfg_we;
    logic [IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    cfg_t                shadow_cfg;
    logic [7:0]          col_cnt;
    logic [7:0]          row_cnt;
    out_item_t           pending_writes[$];
    out_item_t           want;
    int                  mismatches = 0;
    int                  send_idle_pct;
    int                  recv_idle_pct;
    logic                hold_on;
    event                hold_go;

    clipped_color_key_sprite_blit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    // Screen position, clipping and key test for one accepted pixel.
    function automatic void predict_pixel(input logic [15:0] pix, input logic first);
        int          w;
        int          h;
        int          sx;
        int          sy;
        logic [15:0] p;
        out_item_t   wr;
        w = (shadow_cfg.sprite_width == 0) ? 1 : int'(shadow_cfg.sprite_width);
        h = (shadow_cfg.sprite_height == 0) ? 1 : int'(shadow_cfg.sprite_height);
        if (first)
        begin
            col_cnt = '0;
            row_cnt = '0;
        end
        p = (shadow_cfg.pixel_mode == MODE_8BIT) ? {8'h00, pix[7:0]} : pix;
        sx = int'(shadow_cfg.dest_x) + int'(col_cnt);
        sy = int'(shadow_cfg.dest_y) + int'(row_cnt);
        if (sx >= 0 && sx < SCR_W && sy >= 0 && sy < SCR_H &&
            int'(p) != int'(shadow_cfg.key_color))
        begin
            wr.write_address = ADDR_W'(sy * SCR_W + sx);
            wr.write_value   = p;
            pending_writes.push_back(wr);
        end
        if (int'(col_cnt) >= w - 1)
        begin
            col_cnt = '0;
            if (int'(row_cnt) >= h - 1)
                row_cnt = '0;
            else
                row_cnt = row_cnt + 8'd1;
        end
        else
        begin
            col_cnt = col_cnt + 8'd1;
        end
    endfunction

    task automatic send_pixel(input logic [15:0] pix, input logic first);
        in_item_t item;
        item.pixel_value = pix;
        item.first_pixel = first;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_data  <= item;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_pixel(pix, first);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes every register index in turn, including the unused ones.
    task automatic load_config(input int dx, input int dy, input int w, input int h,
                               input int key, input logic mode);
        logic [IDX_W-1:0] idx;
        logic [CFG_W-1:0] data;
        wait_drain();
        for (int i = 0; i < 8; i++)
        begin
            idx = IDX_W'(i);
            case (idx)
                REG_DEST_X:        data = {8'($urandom), 9'(dx)};
                REG_DEST_Y:        data = {8'($urandom), 9'(dy)};
                REG_SPRITE_WIDTH:  data = {9'($urandom), 8'(w)};
                REG_SPRITE_HEIGHT: data = {9'($urandom), 8'(h)};
                REG_KEY_COLOR:     data = 17'(key);
                REG_PIXEL_MODE:    data = {16'($urandom), mode};
                default:           data = 17'($urandom);
            endcase
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            @(posedge clk);
            case (idx)
                REG_DEST_X:        shadow_cfg.dest_x        = signed'(data[8:0]);
                REG_DEST_Y:        shadow_cfg.dest_y        = signed'(data[8:0]);
                REG_SPRITE_WIDTH:  shadow_cfg.sprite_width  = data[7:0];
                REG_SPRITE_HEIGHT: shadow_cfg.sprite_height = data[7:0];
                REG_KEY_COLOR:     shadow_cfg.key_color     = signed'(data);
                REG_PIXEL_MODE:    shadow_cfg.pixel_mode    = data[0];
                default:           ;
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    function automatic int pick_dim();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return 0;
        if (r < 85)
            return $urandom_range(1, 8);
        return $urandom_range(9, 40);
    endfunction

    task automatic test_reset_defaults();
        send_pixel(16'hFFFF, 1'b1);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'hA5C3, 1'b1);
    endtask

    task automatic test_clip_and_key();
        logic [15:0] pix;
        load_config(-2, -1, 4, 3, 'h1234, MODE_16BIT);
        for (int i = 0; i < 13; i++)
        begin
            case (i)
                6:       pix = 16'h1234;
                7:       pix = 16'hFFFF;
                10:      pix = 16'h0000;
                11:      pix = 16'h1235;
                default: pix = 16'($urandom);
            endcase
            send_pixel(pix, i == 0);
        end
        load_config(79, 63, 0, 0, 'hFF, MODE_8BIT);
        send_pixel(16'h12FF, 1'b1);
        send_pixel(16'hAB00, 1'b0);
        send_pixel(16'h00FE, 1'b0);
        load_config(0, 0, 1, 1, 'h1FF, MODE_8BIT);
        send_pixel(16'h01FF, 1'b0);
        load_config(255, 255, 255, 255, -256, MODE_16BIT);
        send_pixel(16'($urandom), 1'b1);
        load_config(-255, -255, 255, 255, -65536, MODE_16BIT);
        send_pixel(16'($urandom), 1'b1);
        load_config(80, 0, 1, 1, -1, MODE_16BIT);
        send_pixel(16'($urandom), 1'b1);
        load_config(0, 64, 1, 1, -1, MODE_16BIT);
        send_pixel(16'($urandom), 1'b1);
        load_config(0, 0, 1, 1, 65535, MODE_16BIT);
        send_pixel(16'hFFFF, 1'b1);
        send_pixel(16'hFFFE, 1'b0);
    endtask

    task automatic test_extreme_sizes();
        load_config(-200, 10, 255, 1, 'h0F0F, MODE_16BIT);
        for (int i = 0; i < 256; i++)
            send_pixel(($urandom_range(3) == 0) ? 16'h0F0F : 16'($urandom), i == 0);
        load_config(5, -200, 1, 255, -1, MODE_8BIT);
        for (int i = 0; i < 256; i++)
            send_pixel(16'($urandom), i == 0);
    endtask

    task automatic test_random_sprites(input int n_items);
        int          sent;
        int          dx;
        int          dy;
        int          w;
        int          h;
        int          key;
        int          len;
        logic        mode;
        logic        first;
        logic [15:0] hot;
        logic [15:0] pix;
        sent = 0;
        while (sent < n_items)
        begin
            dx = ($urandom_range(3) != 0) ? int'($urandom_range(100)) - 12
                                          : int'($urandom_range(510)) - 255;
            dy = ($urandom_range(3) != 0) ? int'($urandom_range(78)) - 8
                                          : int'($urandom_range(510)) - 255;
            w = pick_dim();
            h = pick_dim();
            mode = $urandom_range(1);
            hot = 16'($urandom);
            case ($urandom_range(9))
                0, 1:    key = -1;
                2:       key = -int'($urandom_range(1, 65536));
                3:       key = $urandom_range(16'hFFFF);
                default: key = (mode == MODE_16BIT) ? int'(hot) : int'(hot[7:0]);
            endcase
            load_config(dx, dy, w, h, key, mode);
            repeat ($urandom_range(1, 3))
            begin
                len = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
                if ($urandom_range(9) == 0)
                    len = $urandom_range(1, 2 * len);
                if (len > 120)
                    len = 120;
                for (int i = 0; i < len; i++)
                begin
                    pix = ($urandom_range(2) == 0) ? hot : 16'($urandom);
                    if (mode == MODE_8BIT && $urandom_range(1) == 1)
                        pix[15:8] = 8'($urandom);
                    first = (i == 0);
                    if ($urandom_range(19) == 0)
                        first = !first;
                    send_pixel(pix, first);
                    sent++;
                end
            end
        end
    endtask

    // The receiver stalls while the sender keeps offering items.
    task automatic test_backpressure();
        load_config(0, 0, 16, 4, -1, MODE_16BIT);
        @(negedge clk);
        -> hold_go;
        @(posedge clk);
        for (int i = 0; i < 32; i++)
            send_pixel(16'($urandom), i == 0);
        wait_drain();
        for (int i = 0; i < 32; i++)
            send_pixel(16'($urandom), i == 0);
    endtask

    initial
    begin
        hold_on = 1'b0;
        forever
        begin
            @(hold_go);
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_on <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (hold_on)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_writes.size() == 0)
            begin
                $display("%0t: unexpected write address %0d value %h", $time,
                         out_data.write_address, out_data.write_value);
                mismatches++;
            end
            else
            begin
                want = pending_writes.pop_front();
                if (out_data.write_address !== want.write_address)
                begin
                    $display("%0t: write_address expected %0d actual %0d", $time,
                             want.write_address, out_data.write_address);
                    mismatches++;
                end
                if (out_data.write_value !== want.write_value)
                begin
                    $display("%0t: write_value expected %h actual %h", $time,
                             want.write_value, out_data.write_value);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_ready <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        send_idle_pct = 16;
        recv_idle_pct = 87;
        shadow_cfg.dest_x        = '0;
        shadow_cfg.dest_y        = '0;
        shadow_cfg.sprite_width  = 8'd1;
        shadow_cfg.sprite_height = 8'd1;
        shadow_cfg.key_color     = -17'sd1;
        shadow_cfg.pixel_mode    = MODE_8BIT;
        col_cnt = '0;
        row_cnt = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_clip_and_key();
        test_extreme_sizes();
        test_random_sprites(60);
        wait_drain();
        send_idle_pct = 87;
        recv_idle_pct = 16;
        test_random_sprites(60);
        wait_drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_sprites(60);
        test_backpressure();
        wait_drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_writes.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
